### sv/hslrgbw_pkg.sv
// ============================================================================
// HSL to RGBW converter package
// Shared payload types, channel arithmetic widths and constants.
// ============================================================================
`default_nettype none

package hslrgbw_pkg;

    // Input transaction: one HSL color.
    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [8:0] saturation;
        logic [8:0] lightness;
    } hsl_t;

    // Output transaction: one set of drive levels.
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] white_level;
    } rgbw_t;

    // Channel values in units of 1/(65536*60); wide enough for a channel
    // minus the common minimum.
    localparam int CHAN_W = 27;
    typedef logic signed [CHAN_W-1:0] chan_t;

    // Chroma in units of 1/65536.
    typedef logic signed [18:0] chroma_t;
    // 256 - |2L - 256|.
    typedef logic signed [9:0] span_t;

    // Hue sectors of 60 degrees; a boundary hue belongs to the lower sector.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    localparam logic [8:0] HUE_FULL   = 9'd360;
    localparam logic [8:0] SECTOR_DEG = 9'd60;

    // 1.0 in channel units; levels at or above it saturate.
    localparam chan_t UNIT_ONE = chan_t'(3932160);

    // Level = channel / 15360 = (channel >> 10) / 15.
    localparam int LEVEL_SHIFT = 10;
    localparam int QUO_W       = 12;
    // Reciprocal of 15 scaled by 2^16, rounded up; with a 24-bit product it
    // is exact for dividends below 3840, which covers every unsaturated channel.
    localparam logic [23:0] RECIP_15 = 24'd4370;

endpackage

`default_nettype wire

### sv/hsl_to_rgbw_converter.sv
// ============================================================================
// HSL to RGBW converter
// Fully pipelined fixed-point HSL to RGB or RGBW drive-level conversion.
// ============================================================================
// Usage:
//   A color transaction is taken on every rising edge where start is high
//   and busy is low. busy is never raised, so one color enters per clock.
//   Seven pipeline stages follow: span and hue reduction, chroma multiply,
//   secondary multiply and offset, sector select, white extraction, and two
//   stages of level scaling. Each result appears on rgbw, in input order,
//   with done high for exactly one cycle as it leaves the last
//   level-scaling register. Throughput is one color per cycle.
//   The receiver has no way to stall, so each result must be taken in the
//   cycle it is shown.
//   cfg_write with cfg_data sets the white channel enable. When it is low,
//   white_level is zero and red, green and blue carry the full color. The user
//   must change it only while the pipeline is empty; the block does not check.
//   Reset clears the pipeline valid bits and the white enable; colors in
//   flight are dropped.
// ============================================================================
`default_nettype none

module hsl_to_rgbw_converter
    import hslrgbw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_write,
    input  wire logic  cfg_data,
    input  wire logic  start,
    output      logic  busy,
    input  wire hsl_t  hsl,
    output      logic  done,
    output      rgbw_t rgbw
);

    localparam int STAGES = 7;

    logic              wen_reg;
    logic              wen_next;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    // Stage 1
    logic [8:0]  s1_hue_reg,  s1_hue_next;
    logic [8:0]  s1_sat_reg;
    logic [8:0]  s1_lit_reg;
    span_t       s1_span_reg, s1_span_next;
    logic signed [10:0] dev;
    logic [9:0]  dev_abs;
    logic signed [10:0] span_full;

    // Stage 2
    chroma_t     s2_c_reg,    s2_c_next;
    logic [8:0]  s2_lit_reg;
    sector_t     s2_sec_reg,  s2_sec_next;
    logic [6:0]  s2_frac_reg, s2_frac_next;
    logic [8:0]  hue_mod;

    // Stage 3
    chan_t       s3_cc_reg,   s3_cc_next;
    chan_t       s3_xx_reg,   s3_xx_next;
    chan_t       s3_m_reg,    s3_m_next;
    sector_t     s3_sec_reg;
    chan_t       c_ext;

    // Stage 4
    chan_t       s4_r_reg, s4_r_next;
    chan_t       s4_g_reg, s4_g_next;
    chan_t       s4_b_reg, s4_b_next;

    // Stage 5
    chan_t       s5_r_reg, s5_r_next;
    chan_t       s5_g_reg, s5_g_next;
    chan_t       s5_b_reg, s5_b_next;
    chan_t       s5_w_reg, s5_w_next;
    chan_t       min_rg;
    chan_t       min_rgb;

    // ------------------------------------------------------------------
    // Control: config register and stage valid bits
    // ------------------------------------------------------------------
    always_comb
    begin
        wen_next = cfg_write ? cfg_data : wen_reg;
        vld_next = {vld_reg[STAGES-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wen_reg <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            wen_reg <= wen_next;
            vld_reg <= vld_next;
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: hue reduction and 256 - |2L - 256|
    // ------------------------------------------------------------------
    always_comb
    begin
        if (hsl.hue_degrees >= HUE_FULL)
        begin
            s1_hue_next = hsl.hue_degrees - HUE_FULL;
        end
        else
        begin
            s1_hue_next = hsl.hue_degrees;
        end
        dev          = $signed({1'b0, hsl.lightness, 1'b0}) - 11'sd256;
        dev_abs      = dev[10] ? 10'(-dev) : dev[9:0];
        span_full    = 11'sd256 - $signed({1'b0, dev_abs});
        s1_span_next = span_full[9:0];
    end

    always_ff @(posedge clk)
    begin
        s1_hue_reg  <= s1_hue_next;
        s1_sat_reg  <= hsl.saturation;
        s1_lit_reg  <= hsl.lightness;
        s1_span_reg <= s1_span_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma multiply, sector and position within the sector pair
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_c_next = chroma_t'(s1_span_reg) * chroma_t'({1'b0, s1_sat_reg});

        if (s1_hue_reg <= SECTOR_DEG)
        begin
            s2_sec_next = SEC_RED_YEL;
        end
        else if (s1_hue_reg <= 9'(2 * SECTOR_DEG))
        begin
            s2_sec_next = SEC_YEL_GRN;
        end
        else if (s1_hue_reg <= 9'(3 * SECTOR_DEG))
        begin
            s2_sec_next = SEC_GRN_CYN;
        end
        else if (s1_hue_reg <= 9'(4 * SECTOR_DEG))
        begin
            s2_sec_next = SEC_CYN_BLU;
        end
        else if (s1_hue_reg <= 9'(5 * SECTOR_DEG))
        begin
            s2_sec_next = SEC_BLU_MAG;
        end
        else
        begin
            s2_sec_next = SEC_MAG_RED;
        end

        // Hue modulo 120, then the triangle 60 - |t - 60|.
        if (s1_hue_reg < 9'(2 * SECTOR_DEG))
        begin
            hue_mod = s1_hue_reg;
        end
        else if (s1_hue_reg < 9'(4 * SECTOR_DEG))
        begin
            hue_mod = s1_hue_reg - 9'(2 * SECTOR_DEG);
        end
        else
        begin
            hue_mod = s1_hue_reg - 9'(4 * SECTOR_DEG);
        end
        if (hue_mod <= SECTOR_DEG)
        begin
            s2_frac_next = hue_mod[6:0];
        end
        else
        begin
            s2_frac_next = 7'(9'(2 * SECTOR_DEG) - hue_mod);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_c_reg    <= s2_c_next;
        s2_lit_reg  <= s1_lit_reg;
        s2_sec_reg  <= s2_sec_next;
        s2_frac_reg <= s2_frac_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: chroma and secondary in channel units, offset m
    // ------------------------------------------------------------------
    always_comb
    begin
        c_ext      = chan_t'(s2_c_reg);
        s3_cc_next = c_ext * chan_t'(60);
        s3_xx_next = c_ext * chan_t'(s2_frac_reg);
        s3_m_next  = chan_t'(s2_lit_reg) * chan_t'(15360) - c_ext * chan_t'(30);
    end

    always_ff @(posedge clk)
    begin
        s3_cc_reg  <= s3_cc_next;
        s3_xx_reg  <= s3_xx_next;
        s3_m_reg   <= s3_m_next;
        s3_sec_reg <= s2_sec_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: sector routing plus offset
    // ------------------------------------------------------------------
    always_comb
    begin
        case (s3_sec_reg)
            SEC_RED_YEL:
            begin
                s4_r_next = s3_cc_reg;
                s4_g_next = s3_xx_reg;
                s4_b_next = '0;
            end
            SEC_YEL_GRN:
            begin
                s4_r_next = s3_xx_reg;
                s4_g_next = s3_cc_reg;
                s4_b_next = '0;
            end
            SEC_GRN_CYN:
            begin
                s4_r_next = '0;
                s4_g_next = s3_cc_reg;
                s4_b_next = s3_xx_reg;
            end
            SEC_CYN_BLU:
            begin
                s4_r_next = '0;
                s4_g_next = s3_xx_reg;
                s4_b_next = s3_cc_reg;
            end
            SEC_BLU_MAG:
            begin
                s4_r_next = s3_xx_reg;
                s4_g_next = '0;
                s4_b_next = s3_cc_reg;
            end
            default:
            begin
                s4_r_next = s3_cc_reg;
                s4_g_next = '0;
                s4_b_next = s3_xx_reg;
            end
        endcase
        s4_r_next = s4_r_next + s3_m_reg;
        s4_g_next = s4_g_next + s3_m_reg;
        s4_b_next = s4_b_next + s3_m_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_r_reg <= s4_r_next;
        s4_g_reg <= s4_g_next;
        s4_b_reg <= s4_b_next;
    end

    // ------------------------------------------------------------------
    // Stage 5: when white is enabled, move the common minimum into white
    // ------------------------------------------------------------------
    always_comb
    begin
        min_rg  = (s4_g_reg < s4_r_reg) ? s4_g_reg : s4_r_reg;
        min_rgb = (s4_b_reg < min_rg) ? s4_b_reg : min_rg;
        if (wen_reg)
        begin
            s5_r_next = s4_r_reg - min_rgb;
            s5_g_next = s4_g_reg - min_rgb;
            s5_b_next = s4_b_reg - min_rgb;
            s5_w_next = min_rgb;
        end
        else
        begin
            s5_r_next = s4_r_reg;
            s5_g_next = s4_g_reg;
            s5_b_next = s4_b_reg;
            s5_w_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_r_reg <= s5_r_next;
        s5_g_reg <= s5_g_next;
        s5_b_reg <= s5_b_next;
        s5_w_reg <= s5_w_next;
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: clamp and scale to 8-bit levels
    // ------------------------------------------------------------------
    hslrgbw_level u_level_red
    (
        .clk   (clk),
        .value (s5_r_reg),
        .level (rgbw.red_level)
    );

    hslrgbw_level u_level_green
    (
        .clk   (clk),
        .value (s5_g_reg),
        .level (rgbw.green_level)
    );

    hslrgbw_level u_level_blue
    (
        .clk   (clk),
        .value (s5_b_reg),
        .level (rgbw.blue_level)
    );

    hslrgbw_level u_level_white
    (
        .clk   (clk),
        .value (s5_w_reg),
        .level (rgbw.white_level)
    );

    assign done = vld_reg[STAGES-1];

endmodule

`default_nettype wire

### sv/hslrgbw_level.sv
// ============================================================================
// Channel to drive level
// Two-stage clamp and divide-by-15360 of one channel value, saturating at 255.
// ============================================================================
`default_nettype none

module hslrgbw_level
    import hslrgbw_pkg::*;
(
    input  wire logic        clk,
    input  wire chan_t       value,
    output      logic [7:0]  level
);

    logic [QUO_W-1:0] x_reg;
    logic [QUO_W-1:0] x_next;
    logic             sat_reg;
    logic             sat_next;
    logic [7:0]       level_reg;
    logic [7:0]       level_next;
    logic [23:0]      prod;

    always_comb
    begin
        sat_next = (value >= UNIT_ONE);
        if (value <= chan_t'(0))
        begin
            x_next = '0;
        end
        else
        begin
            x_next = value[LEVEL_SHIFT+QUO_W-1:LEVEL_SHIFT];
        end
    end

    // The quotient by 15 comes from a multiply by the rounded-up reciprocal.
    always_comb
    begin
        prod = 24'(x_reg) * RECIP_15;
        if (sat_reg)
        begin
            level_next = 8'hFF;
        end
        else
        begin
            level_next = prod[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        sat_reg   <= sat_next;
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

`default_nettype wire

### sv/hslrgbw_checker.sv
// ============================================================================
// HSL to RGBW converter checker
// Port-level assertions on busy, latency and white extraction, bound to the top.
// ============================================================================
`default_nettype none

module hslrgbw_checker
    import hslrgbw_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  start,
    input wire logic  busy,
    input wire logic  done,
    input wire rgbw_t rgbw
);

    // The pipeline never pushes back.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted transaction is followed by a result on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing seven cycles after start");

    // No result appears without a matching earlier transaction.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 7))
        else $error("result without a matching start");

    // A nonzero white level means the common minimum was removed from all colors, so one of them is zero.
    a_white_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rgbw.white_level != 8'd0) |->
            (rgbw.red_level == 8'd0 || rgbw.green_level == 8'd0 ||
             rgbw.blue_level == 8'd0))
        else $error("white level set while all colors are nonzero");

endmodule

bind hsl_to_rgbw_converter hslrgbw_checker u_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rgbw  (rgbw)
);

`default_nettype wire
